// ----- hdl/geodetic_to_local_enu_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the geodetic to local ENU block
// Shared macros for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GEODETIC_TO_LOCAL_ENU_DEFINES_SVH
`define GEODETIC_TO_LOCAL_ENU_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define G2E_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("g2e assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define G2E_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("g2e assertion failed");

`endif

// ----- hdl/g2e_pkg.sv -----
// ----------------------------------------------------------------------------
// Geodetic to local ENU package
// Fixed-point formats, series constants, shared types and rounding helper.
// ----------------------------------------------------------------------------
package g2e_pkg;

   localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
   localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
   localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;

   localparam longint ONE_Q30    = 64'sd1073741824;
   localparam longint TWO_POW_34 = 64'sd17179869184;
   localparam int     RCP_SHIFT  = 34;

   // Taylor terms: sine runs to x^17, cosine to x^18
   localparam int N_SIN = 8;
   localparam int N_COS = 9;

   localparam longint SIN_DIV [N_SIN] = '{6, 20, 42, 72, 110, 156, 210, 272};
   localparam longint COS_DIV [N_COS] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

   localparam longint SIN_RCP [N_SIN] = '{
      TWO_POW_34 / 6,   TWO_POW_34 / 20,  TWO_POW_34 / 42,  TWO_POW_34 / 72,
      TWO_POW_34 / 110, TWO_POW_34 / 156, TWO_POW_34 / 210, TWO_POW_34 / 272};
   localparam longint COS_RCP [N_COS] = '{
      TWO_POW_34 / 2,   TWO_POW_34 / 12,  TWO_POW_34 / 30,  TWO_POW_34 / 56,
      TWO_POW_34 / 90,  TWO_POW_34 / 132, TWO_POW_34 / 182, TWO_POW_34 / 240,
      TWO_POW_34 / 306};

   // wrap, fold, square, three stages per term, final clamp
   localparam int SC_LAT  = 3 + 3 * N_COS + 1;
   localparam int ENU_LAT = 6;
   localparam int TOT_LAT = SC_LAT + ENU_LAT;

   localparam longint RADIUS_UNITS = 64'sd407744000;
   localparam logic signed [30:0] OUT_LIMIT = 31'sd815488000;

   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] c;
   } trig_type;

   typedef enum logic [0:0] {
      REG_REF_LAT = 1'b0,
      REG_REF_LON = 1'b1
   } csr_reg_type;

   // Drop 30 fraction bits, round to nearest with ties away from zero
   function automatic logic signed [71:0] round_q30(input logic signed [71:0] p);
      logic [71:0] mag;
      logic [71:0] r;
      if (p < 0) begin
         mag = 72'(0) - p;
         r = (mag + 72'd536870912) >> 30;
         return $signed(72'(0) - r);
      end else begin
         mag = p;
         r = (mag + 72'd536870912) >> 30;
         return $signed(r);
      end
   endfunction

endpackage

// ----- hdl/g2e_sincos.sv -----
// ----------------------------------------------------------------------------
// Pipelined sine and cosine
// Range reduction, then one Taylor term per three stages, Q29 in, Q30 out.
// ----------------------------------------------------------------------------
module g2e_sincos (
   input  logic                clock,
   input  logic                en,
   input  logic signed [31:0]  angle,
   output g2e_pkg::trig_type   trig
);
   import g2e_pkg::*;

   logic signed [33:0] a_ext;
   logic signed [33:0] w_in;
   logic signed [33:0] w_ff;
   logic signed [33:0] mag_abs;
   logic signed [33:0] mag_fold;
   logic               neg_s_in;
   logic               neg_c_in;
   logic [30:0]        x_in;
   logic [30:0]        x_ff;
   logic               neg_s0_ff;
   logic               neg_c0_ff;
   logic [61:0]        xsq;

   logic [31:0]        x2_ff  [0:N_COS];
   logic [31:0]        ts_ff  [0:N_COS];
   logic [31:0]        tc_ff  [0:N_COS];
   logic signed [34:0] ss_ff  [0:N_COS];
   logic signed [34:0] sc_ff  [0:N_COS];
   logic               ns_ff  [0:N_COS];
   logic               nc_ff  [0:N_COS];

   logic signed [34:0] s_clamp;
   logic signed [34:0] c_clamp;
   trig_type           trig_ff;

   // wrap once by 2*pi
   always_comb begin
      a_ext = {{2{angle[31]}}, angle};
      if (a_ext > PI_Q29) begin
         w_in = a_ext - TWO_PI_Q29;
      end else if (a_ext < -PI_Q29) begin
         w_in = a_ext + TWO_PI_Q29;
      end else begin
         w_in = a_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= w_in;
      end
   end

   // fold into the first quadrant
   always_comb begin
      neg_s_in = w_ff < 0;
      mag_abs  = neg_s_in ? -w_ff : w_ff;
      neg_c_in = mag_abs > HALF_PI_Q29;
      mag_fold = neg_c_in ? (PI_Q29 - mag_abs) : mag_abs;
      if (mag_fold < 0) begin
         mag_fold = '0;
      end
      x_in = {mag_fold[29:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff      <= x_in;
         neg_s0_ff <= neg_s_in;
         neg_c0_ff <= neg_c_in;
      end
   end

   assign xsq = 62'(x_ff) * 62'(x_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff[0] <= xsq[61:30];
         ts_ff[0] <= 32'(x_ff);
         tc_ff[0] <= 32'(ONE_Q30);
         ss_ff[0] <= $signed(35'(x_ff));
         sc_ff[0] <= 35'(ONE_Q30);
         ns_ff[0] <= neg_s0_ff;
         nc_ff[0] <= neg_c0_ff;
      end
   end

   for (genvar k = 0; k < N_COS; k++) begin : g_term
      localparam logic [33:0] C_RCP = 34'(COS_RCP[k]);
      localparam logic [8:0]  C_DIV = 9'(COS_DIV[k]);

      logic [63:0]        pc_ff;
      logic [31:0]        a_x2_ff;
      logic [31:0]        a_ts_ff;
      logic signed [34:0] a_ss_ff;
      logic signed [34:0] a_sc_ff;
      logic               a_ns_ff;
      logic               a_nc_ff;

      logic [32:0]        yc_ff;
      logic [66:0]        mc_ff;
      logic [31:0]        b_x2_ff;
      logic [31:0]        b_ts_ff;
      logic signed [34:0] b_ss_ff;
      logic signed [34:0] b_sc_ff;
      logic               b_ns_ff;
      logic               b_nc_ff;

      logic [32:0]        qc0;
      logic [41:0]        qc_chk;
      logic [32:0]        qc;
      logic [31:0]        tc_in;
      logic signed [34:0] sc_in;

      // product of term and x^2
      always_ff @(posedge clock) begin
         if (en) begin
            pc_ff   <= 64'(tc_ff[k]) * 64'(x2_ff[k]);
            a_x2_ff <= x2_ff[k];
            a_ts_ff <= ts_ff[k];
            a_ss_ff <= ss_ff[k];
            a_sc_ff <= sc_ff[k];
            a_ns_ff <= ns_ff[k];
            a_nc_ff <= nc_ff[k];
         end
      end

      // reciprocal multiply for the constant divide
      always_ff @(posedge clock) begin
         if (en) begin
            yc_ff   <= pc_ff[62:30];
            mc_ff   <= 67'(pc_ff[62:30]) * 67'(C_RCP);
            b_x2_ff <= a_x2_ff;
            b_ts_ff <= a_ts_ff;
            b_ss_ff <= a_ss_ff;
            b_sc_ff <= a_sc_ff;
            b_ns_ff <= a_ns_ff;
            b_nc_ff <= a_nc_ff;
         end
      end

      // quotient may be one short: fix and accumulate
      always_comb begin
         qc0    = mc_ff[66:RCP_SHIFT];
         qc_chk = 42'(qc0 + 33'd1) * 42'(C_DIV);
         qc     = (qc_chk <= 42'(yc_ff)) ? qc0 + 33'd1 : qc0;
         tc_in  = qc[31:0];
         if (k % 2 == 0) begin
            sc_in = b_sc_ff - $signed({3'b000, tc_in});
         end else begin
            sc_in = b_sc_ff + $signed({3'b000, tc_in});
         end
      end

      if (k < N_SIN) begin : g_sin
         localparam logic [33:0] S_RCP = 34'(SIN_RCP[k]);
         localparam logic [8:0]  S_DIV = 9'(SIN_DIV[k]);

         logic [63:0]        ps_ff;
         logic [32:0]        ys_ff;
         logic [66:0]        ms_ff;
         logic [32:0]        qs0;
         logic [41:0]        qs_chk;
         logic [32:0]        qs;
         logic [31:0]        ts_in;
         logic signed [34:0] ss_in;

         always_ff @(posedge clock) begin
            if (en) begin
               ps_ff <= 64'(ts_ff[k]) * 64'(x2_ff[k]);
               ys_ff <= ps_ff[62:30];
               ms_ff <= 67'(ps_ff[62:30]) * 67'(S_RCP);
            end
         end

         always_comb begin
            qs0    = ms_ff[66:RCP_SHIFT];
            qs_chk = 42'(qs0 + 33'd1) * 42'(S_DIV);
            qs     = (qs_chk <= 42'(ys_ff)) ? qs0 + 33'd1 : qs0;
            ts_in  = qs[31:0];
            if (k % 2 == 0) begin
               ss_in = b_ss_ff - $signed({3'b000, ts_in});
            end else begin
               ss_in = b_ss_ff + $signed({3'b000, ts_in});
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               ts_ff[k+1] <= ts_in;
               ss_ff[k+1] <= ss_in;
            end
         end
      end else begin : g_sin_hold
         always_ff @(posedge clock) begin
            if (en) begin
               ts_ff[k+1] <= b_ts_ff;
               ss_ff[k+1] <= b_ss_ff;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x2_ff[k+1] <= b_x2_ff;
            tc_ff[k+1] <= tc_in;
            sc_ff[k+1] <= sc_in;
            ns_ff[k+1] <= b_ns_ff;
            nc_ff[k+1] <= b_nc_ff;
         end
      end
   end

   // clamp to [0, 1.0] and restore quadrant signs
   always_comb begin
      s_clamp = ss_ff[N_COS];
      if (s_clamp < 0) begin
         s_clamp = '0;
      end else if (s_clamp > 35'(ONE_Q30)) begin
         s_clamp = 35'(ONE_Q30);
      end
      c_clamp = sc_ff[N_COS];
      if (c_clamp < 0) begin
         c_clamp = '0;
      end else if (c_clamp > 35'(ONE_Q30)) begin
         c_clamp = 35'(ONE_Q30);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff.s <= ns_ff[N_COS] ? -s_clamp[31:0] : s_clamp[31:0];
         trig_ff.c <= nc_ff[N_COS] ? -c_clamp[31:0] : c_clamp[31:0];
      end
   end

   assign trig = trig_ff;

endmodule

// ----- hdl/g2e_enu.sv -----
// ----------------------------------------------------------------------------
// ENU rotation and output scaling
// Unit-sphere difference rotated into the reference frame, scaled to 1/64 m.
// ----------------------------------------------------------------------------
module g2e_enu (
   input  logic                clock,
   input  logic                en,
   input  g2e_pkg::trig_type   pt_lat,
   input  g2e_pkg::trig_type   pt_lon,
   input  g2e_pkg::trig_type   rf_lat,
   input  g2e_pkg::trig_type   rf_lon,
   output logic signed [30:0]  east,
   output logic signed [30:0]  north,
   output logic signed [30:0]  up
);
   import g2e_pkg::*;

   // stage 1: sphere products
   logic signed [63:0] p_v0p_ff, p_v1p_ff, p_v0r_ff, p_v1r_ff, p_scl_ff, p_ssl_ff;
   logic signed [31:0] r1_psp_ff, r1_sp_ff, r1_cp_ff, r1_sl_ff, r1_cl_ff;

   // stage 2: rounded coefficients and differences
   logic signed [32:0] d0_ff, d1_ff, d2_ff;
   logic signed [32:0] nsl_ff, cl_ff, nscl_ff, nssl_ff, cp_ff, cc_ff, cs_ff, sp_ff;
   logic signed [32:0] v0p, v1p, v0r, v1r, scl, ssl;

   // stage 3: rotation products
   logic signed [65:0] e1_ff, e2_ff, n1_ff, n2_ff, n3_ff, u1_ff, u2_ff, u3_ff;

   // stage 4: components in Q30
   logic signed [35:0] e_ff, n_ff, u_ff;

   // stage 5: scaled
   logic signed [65:0] me_ff, mn_ff, mu_ff;

   // stage 6: output
   logic signed [30:0] east_ff, north_ff, up_ff;

   function automatic logic signed [35:0] rnd36(input logic signed [65:0] p);
      logic signed [71:0] r;
      r = round_q30(72'(p));
      return r[35:0];
   endfunction

   function automatic logic signed [30:0] sat_out(input logic signed [65:0] m);
      logic signed [71:0] r;
      r = round_q30(72'(m));
      if (r > 72'(OUT_LIMIT)) begin
         return OUT_LIMIT;
      end else if (r < -72'(OUT_LIMIT)) begin
         return -OUT_LIMIT;
      end else begin
         return r[30:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         p_v0p_ff  <= 64'(pt_lat.c) * 64'(pt_lon.c);
         p_v1p_ff  <= 64'(pt_lat.c) * 64'(pt_lon.s);
         p_v0r_ff  <= 64'(rf_lat.c) * 64'(rf_lon.c);
         p_v1r_ff  <= 64'(rf_lat.c) * 64'(rf_lon.s);
         p_scl_ff  <= 64'(rf_lat.s) * 64'(rf_lon.c);
         p_ssl_ff  <= 64'(rf_lat.s) * 64'(rf_lon.s);
         r1_psp_ff <= pt_lat.s;
         r1_sp_ff  <= rf_lat.s;
         r1_cp_ff  <= rf_lat.c;
         r1_sl_ff  <= rf_lon.s;
         r1_cl_ff  <= rf_lon.c;
      end
   end

   assign v0p = 33'(rnd36(66'(p_v0p_ff)));
   assign v1p = 33'(rnd36(66'(p_v1p_ff)));
   assign v0r = 33'(rnd36(66'(p_v0r_ff)));
   assign v1r = 33'(rnd36(66'(p_v1r_ff)));
   assign scl = 33'(rnd36(66'(p_scl_ff)));
   assign ssl = 33'(rnd36(66'(p_ssl_ff)));

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff   <= v0p - v0r;
         d1_ff   <= v1p - v1r;
         d2_ff   <= 33'(r1_psp_ff) - 33'(r1_sp_ff);
         nsl_ff  <= -33'(r1_sl_ff);
         cl_ff   <= 33'(r1_cl_ff);
         nscl_ff <= -scl;
         nssl_ff <= -ssl;
         cp_ff   <= 33'(r1_cp_ff);
         cc_ff   <= v0r;
         cs_ff   <= v1r;
         sp_ff   <= 33'(r1_sp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff <= 66'(nsl_ff) * 66'(d0_ff);
         e2_ff <= 66'(cl_ff) * 66'(d1_ff);
         n1_ff <= 66'(nscl_ff) * 66'(d0_ff);
         n2_ff <= 66'(nssl_ff) * 66'(d1_ff);
         n3_ff <= 66'(cp_ff) * 66'(d2_ff);
         u1_ff <= 66'(cc_ff) * 66'(d0_ff);
         u2_ff <= 66'(cs_ff) * 66'(d1_ff);
         u3_ff <= 66'(sp_ff) * 66'(d2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= rnd36(e1_ff) + rnd36(e2_ff);
         n_ff <= rnd36(n1_ff) + rnd36(n2_ff) + rnd36(n3_ff);
         u_ff <= rnd36(u1_ff) + rnd36(u2_ff) + rnd36(u3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         me_ff <= 66'(e_ff) * 66'(RADIUS_UNITS);
         mn_ff <= 66'(n_ff) * 66'(RADIUS_UNITS);
         mu_ff <= 66'(u_ff) * 66'(RADIUS_UNITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         east_ff  <= sat_out(me_ff);
         north_ff <= sat_out(mn_ff);
         up_ff    <= sat_out(mu_ff);
      end
   end

   assign east  = east_ff;
   assign north = north_ff;
   assign up    = up_ff;

endmodule

// ----- hdl/geodetic_to_local_enu.sv -----
// ----------------------------------------------------------------------------
// Geodetic to local ENU converter
// Spherical-earth latitude/longitude to east, north, up offsets from a
// configurable reference point.
// ----------------------------------------------------------------------------
// Accepts one position per clock unless the output is stalled, and returns
// its east/north/up offsets after series sine/cosine, one Taylor term per
// three stages, then rotation and scaling. The whole pipeline holds
// while a result waits on rsp_tready. Angles are Q29 radians, offsets are
// 1/64 m saturated to twice the earth radius. Write the reference registers
// only while no item is in flight.
module geodetic_to_local_enu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_latitude[30:0], point_longitude[62:31]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // east_offset[30:0], north_offset[61:31], up_offset[92:62]
   input  logic        csr_wen,
   input  logic [0:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import g2e_pkg::*;
   `include "geodetic_to_local_enu_defines.svh"

   logic signed [30:0]   ref_lat_ff;
   logic signed [31:0]   ref_lon_ff;
   logic [TOT_LAT-1:0]   vld_ff;
   logic                 en;
   trig_type             pt_lat, pt_lon, rf_lat, rf_lon;
   logic signed [30:0]   east, north, up;
   csr_reg_type          csr_reg;

   assign csr_reg = csr_reg_type'(csr_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff <= 31'sd510494981;
         ref_lon_ff <= 32'sd173847928;
      end else if (csr_wen) begin
         unique case (csr_reg)
            REG_REF_LAT: ref_lat_ff <= csr_wdata[30:0];
            REG_REF_LON: ref_lon_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance everything unless a finished item is stuck at the output
   assign en         = !vld_ff[TOT_LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOT_LAT-2:0], req_tvalid};
      end
   end

   g2e_sincos u_sc_plat (
      .clock (clock),
      .en    (en),
      .angle ({req_tdata[30], req_tdata[30:0]}),
      .trig  (pt_lat)
   );

   g2e_sincos u_sc_plon (
      .clock (clock),
      .en    (en),
      .angle (req_tdata[62:31]),
      .trig  (pt_lon)
   );

   // reference angles travel with each item
   g2e_sincos u_sc_rlat (
      .clock (clock),
      .en    (en),
      .angle ({ref_lat_ff[30], ref_lat_ff}),
      .trig  (rf_lat)
   );

   g2e_sincos u_sc_rlon (
      .clock (clock),
      .en    (en),
      .angle (ref_lon_ff),
      .trig  (rf_lon)
   );

   g2e_enu u_enu (
      .clock  (clock),
      .en     (en),
      .pt_lat (pt_lat),
      .pt_lon (pt_lon),
      .rf_lat (rf_lat),
      .rf_lon (rf_lon),
      .east   (east),
      .north  (north),
      .up     (up)
   );

   assign rsp_tvalid = vld_ff[TOT_LAT-1];
   assign rsp_tdata  = {3'b000, up, north, east};

   `G2E_ASSERT_NEXT(a_enter, req_tvalid && req_tready, vld_ff[0])
   `G2E_ASSERT_NEXT(a_hold, !en, $stable(vld_ff))
   `G2E_ASSERT_IMPL(a_range, rsp_tvalid,
      east >= -OUT_LIMIT && east <= OUT_LIMIT && north >= -OUT_LIMIT &&
      north <= OUT_LIMIT && up >= -OUT_LIMIT && up <= OUT_LIMIT)

endmodule

// ----- verif/geodetic_to_local_enu_check.sv -----
// ----------------------------------------------------------------------------
// Geodetic to local ENU result checker
// Watches the request, response and register channels. For each accepted
// item it predicts the east/north/up offsets from its own copy of the
// reference registers, then compares every response with the oldest
// prediction.
// ----------------------------------------------------------------------------
module geodetic_to_local_enu_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [0:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          failures,
   output int          offsets_pending,
   output int          offsets_seen
);
   import g2e_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [30:0] east;
      logic signed [30:0] north;
      logic signed [30:0] up;
   } enu_type;

   localparam longint PI_A      = 64'sd1686629713;
   localparam longint HALF_PI_A = 64'sd843314857;
   localparam longint TWO_PI_A  = 64'sd3373259426;
   localparam longint UNIT      = 64'sd1073741824;
   localparam longint RADIUS_64 = 64'sd407744000;
   localparam longint CLIP      = 64'sd815488000;

   longint  ref_lat;
   longint  ref_lon;
   enu_type enu_expected[$];

   function automatic longint rnd30(input longint p);
      longint m;
      if (p < 0) begin
         m = -p;
         return -((m + 64'sd536870912) >>> 30);
      end
      return (p + 64'sd536870912) >>> 30;
   endfunction

   function automatic longint mulq(input longint a, input longint b);
      return rnd30(a * b);
   endfunction

   function automatic longint unit_clamp(input longint v);
      if (v < 0) return 0;
      if (v > UNIT) return UNIT;
      return v;
   endfunction

   task automatic series_sincos(input longint ang, output longint s, output longint c);
      bit          neg_s;
      bit          neg_c;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      longint      acc;
      neg_s = 0;
      neg_c = 0;
      if (ang > PI_A) ang = ang - TWO_PI_A;
      else if (ang < -PI_A) ang = ang + TWO_PI_A;
      if (ang < 0) begin
         neg_s = 1;
         ang = -ang;
      end
      if (ang > HALF_PI_A) begin
         ang = PI_A - ang;
         neg_c = 1;
      end
      if (ang < 0) ang = 0;
      x = 64'(ang) << 1;
      x2 = (x * x) >> 30;
      t = x;
      acc = longint'(x);
      for (int k = 1; k <= 8; k++) begin
         t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2) acc = acc - longint'(t);
         else acc = acc + longint'(t);
      end
      acc = unit_clamp(acc);
      s = neg_s ? -acc : acc;
      t = 64'(UNIT);
      acc = UNIT;
      for (int k = 1; k <= 9; k++) begin
         t = ((t * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
         if (k % 2) acc = acc - longint'(t);
         else acc = acc + longint'(t);
      end
      acc = unit_clamp(acc);
      c = neg_c ? -acc : acc;
   endtask

   task automatic sphere_point(input longint lat, input longint lon, output longint v[3]);
      longint sp, cp, sl, cl;
      series_sincos(lat, sp, cp);
      series_sincos(lon, sl, cl);
      v[0] = mulq(cp, cl);
      v[1] = mulq(cp, sl);
      v[2] = sp;
   endtask

   function automatic logic signed [30:0] to_units(input longint q);
      longint m;
      m = rnd30(q * RADIUS_64);
      if (m > CLIP) m = CLIP;
      if (m < -CLIP) m = -CLIP;
      return m[30:0];
   endfunction

   task automatic predict_offsets(input longint lat, input longint lon, output enu_type r);
      longint p[3], q[3], d[3];
      longint sp, cp, sl, cl, e, n, u;
      sphere_point(lat, lon, p);
      sphere_point(ref_lat, ref_lon, q);
      for (int k = 0; k < 3; k++) d[k] = p[k] - q[k];
      series_sincos(ref_lat, sp, cp);
      series_sincos(ref_lon, sl, cl);
      e = mulq(-sl, d[0]) + mulq(cl, d[1]);
      n = mulq(-mulq(sp, cl), d[0]) + mulq(-mulq(sp, sl), d[1]) + mulq(cp, d[2]);
      u = mulq(mulq(cp, cl), d[0]) + mulq(mulq(cp, sl), d[1]) + mulq(sp, d[2]);
      r.east = to_units(e);
      r.north = to_units(n);
      r.up = to_units(u);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (failures < 30)
         $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      enu_type pred;
      enu_type want;
      enu_type got;
      if (reset) begin
         ref_lat <= 64'sd510494981;
         ref_lon <= 64'sd173847928;
         enu_expected.delete();
      end else begin
         if (csr_wen) begin
            case (csr_reg_type'(csr_addr))
               REG_REF_LAT: ref_lat <= longint'($signed(csr_wdata[30:0]));
               REG_REF_LON: ref_lon <= longint'($signed(csr_wdata[31:0]));
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_offsets(longint'($signed(req_tdata[30:0])),
                            longint'($signed(req_tdata[62:31])), pred);
            enu_expected.push_back(pred);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.east = rsp_tdata[30:0];
            got.north = rsp_tdata[61:31];
            got.up = rsp_tdata[92:62];
            offsets_seen++;
            if (enu_expected.size() == 0) begin
               report_mismatch("unexpected result, east", got.east, 0);
            end else begin
               want = enu_expected.pop_front();
               if (got.east !== want.east) report_mismatch("east", got.east, want.east);
               if (got.north !== want.north) report_mismatch("north", got.north, want.north);
               if (got.up !== want.up) report_mismatch("up", got.up, want.up);
            end
         end
      end
      offsets_pending <= enu_expected.size();
   end

   initial begin
      failures = 0;
      offsets_seen = 0;
      offsets_pending = 0;
   end

endmodule

// ----- verif/geodetic_to_local_enu_test.sv -----
// ----------------------------------------------------------------------------
// Geodetic to local ENU testbench
// Drives positions under several reference points with random idle bursts
// and back-pressure; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module geodetic_to_local_enu_test;
   import g2e_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 45;
   localparam logic [30:0] LAT_MAX = 31'sd843314857;
   localparam logic [31:0] LON_MAX = 32'sd1686629713;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [0:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   int  failures;
   int  offsets_pending;
   int  offsets_seen;
   int  cycle_count = 0;
   int  positions_sent = 0;
   int  settings_used = 1;
   bit  sender_calm = 0;
   bit  hold_request = 0;

   always #2 clock = ~clock;

   geodetic_to_local_enu dut (.*);

   geodetic_to_local_enu_check checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("geodetic_to_local_enu: mismatch");
         $finish;
      end
   end

   // receiver: random stall bursts, one long hold on request
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_request = 0;
         end else if (!sender_calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            n = $urandom_range(1, 11);
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_position(input logic [30:0] lat, input logic [31:0] lon);
      int gap;
      if (!sender_calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {1'b0, lon, lat};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      positions_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (offsets_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_reference(input logic [30:0] lat, input logic [31:0] lon);
      settle();
      csr_wen <= 1;
      csr_addr <= REG_REF_LAT;
      csr_wdata <= {lat[30], lat};
      @(posedge clock);
      csr_addr <= REG_REF_LON;
      csr_wdata <= lon;
      @(posedge clock);
      csr_wen <= 0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic random_position();
      logic [30:0] lat;
      logic [31:0] lon;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         // any bit pattern, including out-of-range angles
         lat = 31'($urandom);
         lon = $urandom;
      end else if (mode < 4) begin
         // close to the reference region
         lat = 31'($signed(31'sd510494981) + $signed(31'($urandom_range(0, 2000000)))
               - 31'sd1000000);
         lon = 32'($signed(32'sd173847928) + $signed(32'($urandom_range(0, 2000000)))
               - 32'sd1000000);
      end else begin
         lat = 31'($urandom_range(0, 2 * 843314857) - 843314857);
         lon = 32'(longint'($urandom_range(0, 32'd3373259426)) - 64'sd1686629713);
      end
      send_position(lat, lon);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, poles, the reference itself, out-of-range angles
      send_position(31'd510494981, 32'd173847928);
      send_position('0, '0);
      send_position(LAT_MAX, '0);
      send_position(-LAT_MAX, '0);
      send_position(LAT_MAX, LON_MAX);
      send_position(-LAT_MAX, -LON_MAX);
      send_position('0, LON_MAX);
      send_position('0, -LON_MAX);
      send_position(31'h3fffffff, 32'h7fffffff);
      send_position(31'h40000000, 32'h80000000);
      send_position(31'h7fffffff, 32'hffffffff);
      send_position(31'h3fffffff, 32'h00000000);
      send_position(LAT_MAX + 31'd1, LON_MAX + 32'd1);
      send_position(-LAT_MAX - 31'd1, -LON_MAX - 32'd1);
      send_position(31'd510494982, 32'd173847929);
      send_position(31'd843314856, 32'd3);
      for (int i = 0; i < 150; i++) random_position();

      // sender pauses until everything has come back
      settle();
      for (int i = 0; i < 100; i++) random_position();

      set_reference(LAT_MAX, LON_MAX);
      send_position(-LAT_MAX, -LON_MAX);
      hold_request = 1;
      for (int i = 0; i < 200; i++) random_position();

      set_reference(-LAT_MAX, -LON_MAX);
      send_position(LAT_MAX, LON_MAX);
      for (int i = 0; i < 150; i++) random_position();

      set_reference('0, '0);
      for (int i = 0; i < 150; i++) random_position();

      set_reference(31'h7fffffff, 32'h80000000);
      for (int i = 0; i < 100; i++) random_position();

      set_reference(31'($urandom), $urandom);
      for (int i = 0; i < 50; i++) random_position();
      sender_calm = 1;
      for (int i = 0; i < 150; i++) random_position();

      settle();
      $display("Sent %0d positions under %0d reference settings, checked %0d results.",
               positions_sent, settings_used, offsets_seen);
      if (failures == 0) begin
         $display("geodetic_to_local_enu: match");
      end else begin
         $display("geodetic_to_local_enu: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/g2e_pkg.sv
hdl/g2e_sincos.sv
hdl/g2e_enu.sv
hdl/geodetic_to_local_enu.sv
verif/geodetic_to_local_enu_check.sv
verif/geodetic_to_local_enu_test.sv
